// ===== hdl/mrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrm_pkg: shared types and constants for the 4x4 row multiplier
// Default sizes, the fixed field widths of the ports, the request mode codes
// and the control word that travels with a request along the cell chain.
// ----------------------------------------------------------------------------
package mrm_pkg;

  // Default sizes of the matrix and its number format
  localparam int DIM_DEF        = 4;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed port layout: four element fields of 32 bits and a 2-bit row number
  localparam int NUM_FIELDS = 4;
  localparam int FIELD_W    = 32;
  localparam int ROW_W      = 2;

  // Request modes
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_MUL  = 1'b1
  } mrm_mode_e;

  // Control word carried by each request along the chain
  typedef struct packed {
    logic              vld;
    mrm_mode_e         mode;
    logic [ROW_W-1:0]  row;
  } mrm_ctrl_t;

endpackage

// ===== hdl/mrm_cell.sv =====
// ----------------------------------------------------------------------------
// mrm_cell: one cell of the product chain
// Holds row Idx of the right matrix. Multiplies element Idx of a passing
// left row by that stored row, adds it to the partial sums handed in from
// the previous cell, and hands the request on. Load requests for row Idx
// write the store as they pass, which keeps order with multiply requests.
// ----------------------------------------------------------------------------
module mrm_cell #(
  parameter int Dim       = 4,
  parameter int ElemWidth = 32,
  parameter int Idx       = 0,
  parameter int AccWidth  = 2 * ElemWidth + $clog2(Dim)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  mrm_pkg::mrm_ctrl_t            ctrl_i,
  input  logic signed [ElemWidth-1:0]   left_i [Dim],
  input  logic signed [AccWidth-1:0]    sum_i  [Dim],
  output mrm_pkg::mrm_ctrl_t            ctrl_o,
  output logic signed [ElemWidth-1:0]   left_o [Dim],
  output logic signed [AccWidth-1:0]    sum_o  [Dim]
);
  import mrm_pkg::*;

  localparam int ProdWidth = 2 * ElemWidth;

  mrm_ctrl_t                    ctrl_q;
  logic signed [ElemWidth-1:0]  left_q  [Dim];
  logic signed [AccWidth-1:0]   sum_q   [Dim];
  logic signed [AccWidth-1:0]   prod_q  [Dim];
  logic signed [ElemWidth-1:0]  right_q [Dim];
  logic signed [ProdWidth-1:0]  mul     [Dim];
  logic                         load_hit;

  // Form one product per column from this cell's left element
  always_comb begin
    for (int c = 0; c < Dim; c++) begin
      mul[c] = left_i[Idx] * right_q[c];
    end
  end

  assign load_hit = ctrl_i.vld && (ctrl_i.mode == MODE_LOAD) && (int'(ctrl_i.row) == Idx);

  // Advance the control word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance the payload and register the products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < Dim; c++) begin
        left_q[c] <= left_i[c];
        sum_q[c]  <= sum_i[c];
        prod_q[c] <= AccWidth'(mul[c]);
      end
    end
  end

  // Write the stored row when a load for this row passes
  always_ff @(posedge clk_i) begin
    if (adv_i && load_hit) begin
      for (int c = 0; c < Dim; c++) begin
        right_q[c] <= left_i[c];
      end
    end
  end

  // Hand on the request with the updated partial sums
  assign ctrl_o = ctrl_q;
  always_comb begin
    for (int c = 0; c < Dim; c++) begin
      left_o[c] = left_q[c];
      sum_o[c]  = sum_q[c] + prod_q[c];
    end
  end

endmodule

// ===== hdl/mrm_sat.sv =====
// ----------------------------------------------------------------------------
// mrm_sat: fraction shift and saturation of one column sum
// Shifts the exact sum right by FracBits (toward minus infinity) and clamps
// it to a signed ElemWidth-bit value, flagging any clamp.
// ----------------------------------------------------------------------------
module mrm_sat #(
  parameter int ElemWidth = 32,
  parameter int FracBits  = 16,
  parameter int AccWidth  = 66
) (
  input  logic signed [AccWidth-1:0]   acc_i,
  output logic signed [ElemWidth-1:0]  val_o,
  output logic                         sat_o
);
  import mrm_pkg::*;

  localparam logic [ElemWidth-1:0] MaxVal = {1'b0, {(ElemWidth-1){1'b1}}};
  localparam logic [ElemWidth-1:0] MinVal = {1'b1, {(ElemWidth-1){1'b0}}};

  logic signed [AccWidth-1:0]     shifted;
  logic [AccWidth-ElemWidth:0]    upper;
  logic                           fits;

  // Drop the fraction bits
  assign shifted = acc_i >>> FracBits;

  // Fits when all bits above the result's sign bit match it
  assign upper = shifted[AccWidth-1:ElemWidth-1];
  assign fits  = (&upper) || !(|upper);

  // Clamp toward the sign of the sum
  assign sat_o = !fits;
  assign val_o = fits ? shifted[ElemWidth-1:0] :
                 (acc_i[AccWidth-1] ? MinVal : MaxVal);

endmodule

// ===== hdl/matrix4x4_row_multiply.sv =====
// Path: a request passes the register of each cell in turn, then lands in the output register.
// Throughput: one row request per cycle while the output is not stalled; one product cell
//   per matrix row.
// Load requests pass the chain without producing a result.
// Reset: clears all valid flags; the stored right matrix is undefined until
//   each row has been loaded.
// ----------------------------------------------------------------------------
// matrix4x4_row_multiply: streamed Q16.16 matrix product, left times right
// Mode 0 requests load a right-matrix row into the cell chain; mode 1
// requests carry a left row and yield one saturated product row.
// ----------------------------------------------------------------------------
module matrix4x4_row_multiply #(
  parameter int Dim       = mrm_pkg::DIM_DEF,
  parameter int ElemWidth = mrm_pkg::ELEM_WIDTH_DEF,
  parameter int FracBits  = mrm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [mrm_pkg::ROW_W-1:0]         row_index_i,
  input  logic signed [mrm_pkg::FIELD_W-1:0] elem_0_i,
  input  logic signed [mrm_pkg::FIELD_W-1:0] elem_1_i,
  input  logic signed [mrm_pkg::FIELD_W-1:0] elem_2_i,
  input  logic signed [mrm_pkg::FIELD_W-1:0] elem_3_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mrm_pkg::ROW_W-1:0]         out_row_o,
  output logic signed [mrm_pkg::FIELD_W-1:0] prod_0_o,
  output logic signed [mrm_pkg::FIELD_W-1:0] prod_1_o,
  output logic signed [mrm_pkg::FIELD_W-1:0] prod_2_o,
  output logic signed [mrm_pkg::FIELD_W-1:0] prod_3_o,
  output logic                              overflow_o
);
  import mrm_pkg::*;

  localparam int AccWidth = 2 * ElemWidth + $clog2(Dim);
  localparam int NumOut   = (Dim < NUM_FIELDS) ? Dim : NUM_FIELDS;

  localparam logic [ElemWidth-1:0] MaxE = {1'b0, {(ElemWidth-1){1'b1}}};
  localparam logic [ElemWidth-1:0] MinE = {1'b1, {(ElemWidth-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] MaxFld = FIELD_W'($signed(MaxE));
  localparam logic signed [FIELD_W-1:0] MinFld = FIELD_W'($signed(MinE));

  logic                         adv;
  logic signed [FIELD_W-1:0]    elem_in [NUM_FIELDS];
  mrm_ctrl_t                    ctrl_c  [Dim+1];
  logic signed [ElemWidth-1:0]  left_c  [Dim+1][Dim];
  logic signed [AccWidth-1:0]   sum_c   [Dim+1][Dim];
  logic signed [ElemWidth-1:0]  sat_val [NumOut];
  logic                         sat_flg [NumOut];

  logic                         out_vld_q;
  logic [ROW_W-1:0]             out_row_q;
  logic signed [FIELD_W-1:0]    prod_q   [NUM_FIELDS];
  logic signed [FIELD_W-1:0]    prod_d   [NUM_FIELDS];
  logic                         ovf_q;
  logic                         ovf_d;

  // Advance the whole chain unless a finished result is held back
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Enter the request; rows past the matrix size are dropped
  assign elem_in[0] = elem_0_i;
  assign elem_in[1] = elem_1_i;
  assign elem_in[2] = elem_2_i;
  assign elem_in[3] = elem_3_i;

  assign ctrl_c[0].vld  = in_valid_i && (int'(row_index_i) < Dim);
  assign ctrl_c[0].mode = mrm_mode_e'(mode_i);
  assign ctrl_c[0].row  = row_index_i;

  for (genvar j = 0; j < Dim; j++) begin : g_entry
    if (j < NUM_FIELDS) begin : g_field
      assign left_c[0][j] = elem_in[j][ElemWidth-1:0];
    end else begin : g_zero
      assign left_c[0][j] = '0;
    end
    assign sum_c[0][j] = '0;
  end

  // One cell per right-matrix row
  for (genvar k = 0; k < Dim; k++) begin : g_cell
    mrm_cell #(
      .Dim       (Dim),
      .ElemWidth (ElemWidth),
      .Idx       (k),
      .AccWidth  (AccWidth)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctrl_i (ctrl_c[k]),
      .left_i (left_c[k]),
      .sum_i  (sum_c[k]),
      .ctrl_o (ctrl_c[k+1]),
      .left_o (left_c[k+1]),
      .sum_o  (sum_c[k+1])
    );
  end

  // Shift and saturate each column sum
  for (genvar c = 0; c < NumOut; c++) begin : g_sat
    mrm_sat #(
      .ElemWidth (ElemWidth),
      .FracBits  (FracBits),
      .AccWidth  (AccWidth)
    ) u_sat (
      .acc_i (sum_c[Dim][c]),
      .val_o (sat_val[c]),
      .sat_o (sat_flg[c])
    );
  end

  // Widen the column results and gather the overflow flag
  always_comb begin
    ovf_d = 1'b0;
    for (int c = 0; c < NUM_FIELDS; c++) begin
      prod_d[c] = '0;
    end
    for (int c = 0; c < NumOut; c++) begin
      prod_d[c] = FIELD_W'(sat_val[c]);
      ovf_d     = ovf_d | sat_flg[c];
    end
  end

  // Hold the output request until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ctrl_c[Dim].vld && (ctrl_c[Dim].mode == MODE_MUL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_row_q <= ctrl_c[Dim].row;
      ovf_q     <= ovf_d;
      for (int c = 0; c < NUM_FIELDS; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_row_o   = out_row_q;
  assign prod_0_o    = prod_q[0];
  assign prod_1_o    = prod_q[1];
  assign prod_2_o    = prod_q[2];
  assign prod_3_o    = prod_q[3];
  assign overflow_o  = ovf_q;

  // Stall the input only while a result is waiting
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q)
    else $error("input stalled with no result waiting");

  // A waiting result is not dropped
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q)
    else $error("held result lost");

  // Overflow implies a clamped column value
  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      prod_0_o == MaxFld || prod_0_o == MinFld ||
      prod_1_o == MaxFld || prod_1_o == MinFld ||
      prod_2_o == MaxFld || prod_2_o == MinFld ||
      prod_3_o == MaxFld || prod_3_o == MinFld)
    else $error("overflow flagged without a clamped value");

endmodule

// ===== tb/sv/tb_matrix4x4_row_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_row_multiply: self-checking bench for the 4x4 row multiplier
// Streams right-matrix load requests and left-row multiply requests with
// random gaps and output stalls. A scoreboard keeps its own copy of the right
// matrix, predicts every product row in exact wide arithmetic with the Q16.16
// shift and saturation, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_matrix4x4_row_multiply;
  import mrm_pkg::*;

  localparam int IdleLimit   = 1000;
  localparam int RandItems   = 1600;
  localparam int DrainCycles = DIM_DEF + 12;

  localparam logic [FIELD_W-1:0] QMax = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] QMin = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] QOne = 32'h0001_0000;

  localparam logic signed [127:0] SatMax = 128'sd2147483647;
  localparam logic signed [127:0] SatMin = -128'sd2147483648;

  typedef struct packed {
    mrm_mode_e                         mode;
    logic [ROW_W-1:0]                  row;
    logic [NUM_FIELDS-1:0][FIELD_W-1:0] elem;
  } row_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]                  row;
    logic [NUM_FIELDS-1:0][FIELD_W-1:0] prod;
    logic                              ovf;
  } prod_row_t;

  // Scoreboard: mirrors the right matrix and queues predicted product rows
  class row_product_board;
    logic [FIELD_W-1:0] right_rows [NUM_FIELDS][NUM_FIELDS];
    prod_row_t          pending_rows [$];
    int                 mismatches;

    function new();
      foreach (right_rows[r, c]) right_rows[r][c] = '0;
      mismatches = 0;
    endfunction

    // Exact dot products, floor shift to Q16.16, then clamp to 32 bits
    function prod_row_t multiply_row(row_req_t req);
      prod_row_t          res;
      logic signed [127:0] acc;
      logic signed [63:0]  term;
      res.row = req.row;
      res.ovf = 1'b0;
      for (int c = 0; c < NUM_FIELDS; c++) begin
        acc = '0;
        for (int k = 0; k < NUM_FIELDS; k++) begin
          term = $signed(req.elem[k]) * $signed(right_rows[k][c]);
          acc  = acc + term;
        end
        acc = acc >>> FRAC_BITS_DEF;
        if (acc > SatMax) begin
          res.prod[c] = QMax;
          res.ovf     = 1'b1;
        end else if (acc < SatMin) begin
          res.prod[c] = QMin;
          res.ovf     = 1'b1;
        end else begin
          res.prod[c] = acc[FIELD_W-1:0];
        end
      end
      return res;
    endfunction

    // Update the mirror on a load, queue a prediction on a multiply
    function void note_request(row_req_t req);
      if (req.mode == MODE_LOAD) begin
        for (int c = 0; c < NUM_FIELDS; c++) right_rows[req.row][c] = req.elem[c];
      end else begin
        pending_rows.push_back(multiply_row(req));
      end
    endfunction

    function void check_result(prod_row_t got);
      prod_row_t want;
      logic      bad;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: row %0d prod %h %h %h %h ovf %0b", $realtime,
                   got.row, got.prod[0], got.prod[1], got.prod[2], got.prod[3], got.ovf);
        return;
      end
      want = pending_rows.pop_front();
      bad  = (got.row !== want.row) || (got.ovf !== want.ovf);
      for (int c = 0; c < NUM_FIELDS; c++) bad |= (got.prod[c] !== want.prod[c]);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch exp: row %0d prod %h %h %h %h ovf %0b", $realtime,
                   want.row, want.prod[0], want.prod[1], want.prod[2], want.prod[3],
                   want.ovf);
          $display("[%0t] mismatch got: row %0d prod %h %h %h %h ovf %0b", $realtime,
                   got.row, got.prod[0], got.prod[1], got.prod[2], got.prod[3], got.ovf);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  mrm_mode_e          mode;
  logic [ROW_W-1:0]   row_index;
  logic [FIELD_W-1:0] elem_0, elem_1, elem_2, elem_3;
  logic               out_valid;
  logic               out_stall;
  logic [ROW_W-1:0]   out_row;
  logic [FIELD_W-1:0] prod_0, prod_1, prod_2, prod_3;
  logic               overflow;

  row_product_board board = new();
  int               sent;
  bit               send_burst;
  bit               recv_burst;

  matrix4x4_row_multiply i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .row_index_i (row_index),
    .elem_0_i    (elem_0),
    .elem_1_i    (elem_1),
    .elem_2_i    (elem_2),
    .elem_3_i    (elem_3),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_row_o   (out_row),
    .prod_0_o    (prod_0),
    .prod_1_o    (prod_1),
    .prod_2_o    (prod_2),
    .prod_3_o    (prod_3),
    .overflow_o  (overflow)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic row_req_t make_req(mrm_mode_e m, logic [ROW_W-1:0] r,
                                        logic [FIELD_W-1:0] e0, logic [FIELD_W-1:0] e1,
                                        logic [FIELD_W-1:0] e2, logic [FIELD_W-1:0] e3);
    row_req_t req;
    req.mode    = m;
    req.row     = r;
    req.elem[0] = e0;
    req.elem[1] = e1;
    req.elem[2] = e2;
    req.elem[3] = e3;
    return req;
  endfunction

  // Mostly moderate Q16.16 magnitudes, some full-range words and corner values
  function automatic logic [FIELD_W-1:0] rand_elem();
    logic [FIELD_W-1:0] v;
    int                 pick;
    v    = $urandom;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 5))
        0:       v = QMax;
        1:       v = QMin;
        2:       v = '0;
        3:       v = '1;
        4:       v = QOne;
        default: v = -QOne;
      endcase
    end else if (pick >= 3) begin
      v = $signed(v) >>> $urandom_range(6, 28);
    end
    return v;
  endfunction

  // Wait a random gap, present the request, hold it until accepted
  task automatic send_row(row_req_t req);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid  <= 1'b1;
    mode      <= req.mode;
    row_index <= req.row;
    elem_0    <= req.elem[0];
    elem_1    <= req.elem[1];
    elem_2    <= req.elem[2];
    elem_3    <= req.elem[3];
    do @(posedge clk_i); while (in_stall);
    board.note_request(req);
    sent++;
    if (sent % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Drop the request line, then wait until every expected result is in
  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (board.pending_rows.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stall before each result, then take it and check
  initial begin
    int        hold;
    prod_row_t got;
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, 5);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      got.row     = out_row;
      got.prod[0] = prod_0;
      got.prod[1] = prod_1;
      got.prod[2] = prod_2;
      got.prod[3] = prod_3;
      got.ovf     = overflow;
      board.check_result(got);
      if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
    end
  end

  // Watchdog: stop when neither side has moved for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int total;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    mode       = MODE_LOAD;
    row_index  = '0;
    elem_0     = '0;
    elem_1     = '0;
    elem_2     = '0;
    elem_3     = '0;
    out_stall  = 1'b0;
    sent       = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity right matrix: products equal the left row
    for (int r = 0; r < NUM_FIELDS; r++)
      send_row(make_req(MODE_LOAD, ROW_W'(r), (r == 0) ? QOne : '0, (r == 1) ? QOne : '0,
                        (r == 2) ? QOne : '0, (r == 3) ? QOne : '0));
    send_row(make_req(MODE_MUL, 0, QMax, QMax, QMax, QMax));
    send_row(make_req(MODE_MUL, 1, QMin, QMin, QMin, QMin));
    send_row(make_req(MODE_MUL, 2, QMax, QMin, '1, 32'h1));
    send_row(make_req(MODE_MUL, 3, '0, '0, '0, '0));

    // All-max right matrix: saturation both ways, floor rounding of a negative
    for (int r = 0; r < NUM_FIELDS; r++)
      send_row(make_req(MODE_LOAD, ROW_W'(r), QMax, QMax, QMax, QMax));
    send_row(make_req(MODE_MUL, 0, QMax, QMax, QMax, QMax));
    send_row(make_req(MODE_MUL, 1, QMin, QMin, QMin, QMin));
    send_row(make_req(MODE_MUL, 2, 32'h1, '0, '0, '0));
    send_row(make_req(MODE_MUL, 3, '1, '0, '0, '0));

    // Most negative times most negative
    send_row(make_req(MODE_LOAD, 0, QMin, QMin, QMin, QMin));
    send_row(make_req(MODE_MUL, 0, QMin, '0, '0, '0));
    send_row(make_req(MODE_MUL, 1, QMin, QMax, '0, '0));

    // Hold off until the pipeline is empty
    wait_all_results();
    total = sent + RandItems;

    // Random part: mostly full matrix loads followed by a run of multiplies
    while (sent < total) begin
      if (sent >= total - RandItems / 2 && sent < total - RandItems / 2 + 8)
        wait_all_results();
      if ($urandom_range(0, 9) < 7) begin
        for (int r = 0; r < NUM_FIELDS; r++)
          send_row(make_req(MODE_LOAD, ROW_W'(r),
                            rand_elem(), rand_elem(), rand_elem(), rand_elem()));
        repeat ($urandom_range(2, 8))
          send_row(make_req(MODE_MUL, ROW_W'($urandom_range(0, 3)),
                            rand_elem(), rand_elem(), rand_elem(), rand_elem()));
      end else begin
        repeat ($urandom_range(1, 6))
          send_row(make_req(mrm_mode_e'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 3)),
                            rand_elem(), rand_elem(), rand_elem(), rand_elem()));
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    // Drain and let any stray result show up
    wait_all_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
